// ===== design/sha1bs_pkg.sv =====
// Shared types, constants and command/status records of the SHA-1 byte-stream hasher.
package sha1bs_pkg;

    typedef struct packed {
        logic [7:0] msg_byte;
        logic       byte_present;
        logic       end_of_message;
    } t_in_req;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_number;
        logic        last_word;
    } t_out_res;

    // Initial chaining value; entry 0 is the first digest word.
    localparam logic [4:0][31:0] H_INIT = {
        32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
    };

    localparam logic [31:0] K_R0 = 32'h5A827999;
    localparam logic [31:0] K_R1 = 32'h6ED9EBA1;
    localparam logic [31:0] K_R2 = 32'h8F1BBCDC;
    localparam logic [31:0] K_R3 = 32'hCA62C1D6;

    localparam logic [7:0] PAD_LEAD   = 8'h80;
    localparam logic [5:0] LEN_OFFSET = 6'd56;
    localparam int         ROUNDS     = 80;
    localparam int         NUM_WORDS  = 5;

    // Source of the byte that goes into the block buffer.
    localparam logic [1:0] BSEL_MSG  = 2'd0;
    localparam logic [1:0] BSEL_LEAD = 2'd1;
    localparam logic [1:0] BSEL_ZERO = 2'd2;
    localparam logic [1:0] BSEL_LEN  = 2'd3;

    typedef struct packed {
        logic       absorb;
        logic [1:0] bsel;
        logic       round;
        logic       add;
        logic       out_next;
    } t_dp_cmd;

    typedef struct packed {
        logic [5:0] off;
        logic       rnd_last;
        logic       wi_last;
    } t_dp_sts;

endpackage

// ===== design/sha1bs_dp.sv =====
// Datapath: block buffer and message schedule window, round logic, chaining value, byte count.
module sha1bs_dp import sha1bs_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_dp_cmd    i_cmd,
    input  logic [7:0] i_msg_byte,
    output t_dp_sts    o_sts,
    output t_out_res   o_res
);

    logic [511:0]     r_blk;
    logic [63:0]      r_cnt;
    logic [63:0]      r_bitlen;
    logic [31:0]      r_a, r_b, r_c, r_d, r_e;
    logic [4:0][31:0] r_h;
    logic [6:0]       r_rnd;
    logic [2:0]       r_wi;

    logic [7:0]  abs_byte;
    logic [2:0]  len_idx;
    logic [31:0] w0, w2, w8, w13, w_x, w_new;
    logic [31:0] f_val, k_val, n_a;
    logic [1:0]  phase;

    assign len_idx = ~r_cnt[2:0];

    always_comb begin
        case (i_cmd.bsel)
            BSEL_MSG:  abs_byte = i_msg_byte;
            BSEL_LEAD: abs_byte = PAD_LEAD;
            BSEL_ZERO: abs_byte = 8'h00;
            default:   abs_byte = r_bitlen[{len_idx, 3'b000} +: 8];
        endcase
    end

    // The buffer doubles as the 16-word schedule window; word 0 is W[t].
    assign w0    = r_blk[511:480];
    assign w2    = r_blk[447:416];
    assign w8    = r_blk[255:224];
    assign w13   = r_blk[95:64];
    assign w_x   = w13 ^ w8 ^ w2 ^ w0;
    assign w_new = {w_x[30:0], w_x[31]};

    always_comb begin
        if (r_rnd < 7'd20) begin
            phase = 2'd0;
        end else if (r_rnd < 7'd40) begin
            phase = 2'd1;
        end else if (r_rnd < 7'd60) begin
            phase = 2'd2;
        end else begin
            phase = 2'd3;
        end
        case (phase)
            2'd0: begin
                f_val = (r_b & r_c) | (~r_b & r_d);
                k_val = K_R0;
            end
            2'd1: begin
                f_val = r_b ^ r_c ^ r_d;
                k_val = K_R1;
            end
            2'd2: begin
                f_val = (r_b & r_c) | (r_b & r_d) | (r_c & r_d);
                k_val = K_R2;
            end
            default: begin
                f_val = r_b ^ r_c ^ r_d;
                k_val = K_R3;
            end
        endcase
        n_a = {r_a[26:0], r_a[31:27]} + f_val + r_e + k_val + w0;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.absorb) begin
            r_blk <= {r_blk[503:0], abs_byte};
            r_a   <= r_h[0];
            r_b   <= r_h[1];
            r_c   <= r_h[2];
            r_d   <= r_h[3];
            r_e   <= r_h[4];
            if (i_cmd.bsel == BSEL_LEAD) begin
                r_bitlen <= {r_cnt[60:0], 3'b000};
            end
        end else if (i_cmd.round) begin
            r_blk <= {r_blk[479:0], w_new};
            r_a   <= n_a;
            r_b   <= r_a;
            r_c   <= {r_b[1:0], r_b[31:2]};
            r_d   <= r_c;
            r_e   <= r_d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h   <= H_INIT;
            r_cnt <= '0;
            r_rnd <= '0;
            r_wi  <= '0;
        end else begin
            if (i_cmd.absorb) begin
                r_cnt <= r_cnt + 64'd1;
                r_rnd <= '0;
            end
            if (i_cmd.round) begin
                r_rnd <= r_rnd + 7'd1;
            end
            if (i_cmd.add) begin
                r_h[0] <= r_h[0] + r_a;
                r_h[1] <= r_h[1] + r_b;
                r_h[2] <= r_h[2] + r_c;
                r_h[3] <= r_h[3] + r_d;
                r_h[4] <= r_h[4] + r_e;
            end
            if (i_cmd.out_next) begin
                if (o_sts.wi_last) begin
                    // Digest delivered: start the next message.
                    r_wi  <= '0;
                    r_h   <= H_INIT;
                    r_cnt <= '0;
                end else begin
                    r_wi <= r_wi + 3'd1;
                end
            end
        end
    end

    assign o_sts.off      = r_cnt[5:0];
    assign o_sts.rnd_last = (r_rnd == 7'(ROUNDS - 1));
    assign o_sts.wi_last  = (r_wi == 3'(NUM_WORDS - 1));

    assign o_res.digest_word = r_h[r_wi];
    assign o_res.word_number = r_wi;
    assign o_res.last_word   = o_sts.wi_last;

endmodule

// ===== design/sha1bs_ctrl.sv =====
// Controller: request handshakes, padding sequence, compression and digest output states.
module sha1bs_ctrl import sha1bs_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_in_req i_in_req,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LEAD = 3'd1;
    localparam logic [2:0] S_ZERO = 3'd2;
    localparam logic [2:0] S_LEN  = 3'd3;
    localparam logic [2:0] S_COMP = 3'd4;
    localparam logic [2:0] S_ADD  = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [2:0] r_state, n_state;
    logic [2:0] r_ret, n_ret;
    logic [5:0] off_inc;

    assign off_inc = i_sts.off + 6'd1;

    always_comb begin
        n_state     = r_state;
        n_ret       = r_ret;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_in_req.byte_present) begin
                        o_cmd.absorb = 1'b1;
                        o_cmd.bsel   = BSEL_MSG;
                    end
                    if (i_in_req.byte_present && off_inc == 6'd0) begin
                        n_state = S_COMP;
                        n_ret   = i_in_req.end_of_message ? S_LEAD : S_IDLE;
                    end else if (i_in_req.end_of_message) begin
                        n_state = S_LEAD;
                    end
                end
            end
            S_LEAD, S_ZERO: begin
                o_cmd.absorb = 1'b1;
                o_cmd.bsel   = (r_state == S_LEAD) ? BSEL_LEAD : BSEL_ZERO;
                if (off_inc == 6'd0) begin
                    n_state = S_COMP;
                    n_ret   = S_ZERO;
                end else if (off_inc == LEN_OFFSET) begin
                    n_state = S_LEN;
                end else begin
                    n_state = S_ZERO;
                end
            end
            S_LEN: begin
                o_cmd.absorb = 1'b1;
                o_cmd.bsel   = BSEL_LEN;
                if (off_inc == 6'd0) begin
                    n_state = S_COMP;
                    n_ret   = S_OUT;
                end
            end
            S_COMP: begin
                o_cmd.round = 1'b1;
                if (i_sts.rnd_last) begin
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                o_cmd.add = 1'b1;
                n_state   = r_ret;
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    o_cmd.out_next = 1'b1;
                    if (i_sts.wi_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= S_IDLE;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
        end
    end

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready)
        else $error("input taken while digest words are pending");

    a_comp_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COMP) |-> (i_sts.off == 6'd0))
        else $error("compression started on a partial block");

    a_len_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LEN) |-> (i_sts.off[5:3] == 3'b111))
        else $error("length byte outside the last eight block bytes");

    a_out_after_add: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == S_ADD && i_sts.off == 6'd0))
        else $error("digest shown before the final block was folded in");

endmodule

// ===== design/sha1_byte_stream_hasher.sv =====
// Top level of the SHA-1 byte-stream hasher: controller and datapath.
//
//   channel   direction  handshake                  payload
//   input     in         i_in_valid / o_in_ready    i_in_data  (t_in_req)
//   output    out        o_out_valid / i_out_ready  o_out_data (t_out_res)
//
// A message byte is taken in the idle state. Every 64th byte starts a compression: 80 rounds on the
// single round unit, then a step that folds the result into the chaining value.
// A closing request adds the padding bytes (9 to 72), the compressions they complete,
// and the digest words; no request is taken meanwhile.
// Reset is synchronous, active low, and restores the initial chaining value at once.
// A stall on the output holds the current digest word and blocks new requests.
module sha1_byte_stream_hasher import sha1bs_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_in_req  i_in_data,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_out_res o_out_data
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    sha1bs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_req    (i_in_data),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    sha1bs_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_msg_byte (i_in_data.msg_byte),
        .o_sts      (sts),
        .o_res      (o_out_data)
    );

endmodule

// ===== bench/sha1_byte_stream_hasher_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the SHA-1 byte-stream hasher: byte streams checked against a predictor.
module sha1_byte_stream_hasher_test;
    import sha1bs_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 300;
    localparam int IDLE_PERCENT  = 17;
    localparam int ITEM_TARGET   = 170;

    typedef struct {
        t_in_req req;
        bit      drain_first;
    } t_feed_item;

    logic     i_clk = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     i_in_valid = 1'b0;
    logic     o_in_ready;
    t_in_req  i_in_data = '0;
    logic     o_out_valid;
    logic     i_out_ready = 1'b0;
    t_out_res o_out_data;

    t_feed_item byte_feed[$];
    t_out_res   digest_words_due[$];

    // Predicted hasher state.
    logic [31:0] chain_words [5];
    logic [7:0]  block_bytes [64];
    logic [63:0] byte_total;

    int       mismatch_count = 0;
    int       requests_sent = 0;
    int       digests_seen = 0;
    int       cycle_count = 0;
    int       stimulus_items = 0;
    bit       sender_calm;
    bit       receiver_calm;
    t_out_res due_word;

    sha1_byte_stream_hasher u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic logic [31:0] rol(logic [31:0] x, int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    task automatic sha1_restart();
        for (int i = 0; i < 5; i++) begin
            chain_words[i] = H_INIT[i];
        end
        byte_total = '0;
    endtask

    task automatic sha1_compress();
        logic [31:0] w [80];
        logic [31:0] a, b, c, d, e, f, k, t;
        for (int i = 0; i < 16; i++) begin
            w[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2], block_bytes[4*i+3]};
        end
        for (int i = 16; i < 80; i++) begin
            w[i] = rol(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
        end
        a = chain_words[0];
        b = chain_words[1];
        c = chain_words[2];
        d = chain_words[3];
        e = chain_words[4];
        for (int i = 0; i < 80; i++) begin
            if (i < 20) begin
                f = (b & c) | (~b & d);
                k = K_R0;
            end else if (i < 40) begin
                f = b ^ c ^ d;
                k = K_R1;
            end else if (i < 60) begin
                f = (b & c) | (b & d) | (c & d);
                k = K_R2;
            end else begin
                f = b ^ c ^ d;
                k = K_R3;
            end
            t = rol(a, 5) + f + e + k + w[i];
            e = d;
            d = c;
            c = rol(b, 30);
            b = a;
            a = t;
        end
        chain_words[0] += a;
        chain_words[1] += b;
        chain_words[2] += c;
        chain_words[3] += d;
        chain_words[4] += e;
    endtask

    task automatic sha1_absorb(logic [7:0] v);
        block_bytes[byte_total[5:0]] = v;
        byte_total++;
        if (byte_total[5:0] == 6'd0) begin
            sha1_compress();
        end
    endtask

    // Updates the predicted state for one accepted request and queues the digest it closes.
    task automatic sha1_take_request(t_in_req r);
        logic [63:0] bit_len;
        t_out_res    word;
        if (r.byte_present) begin
            sha1_absorb(r.msg_byte);
        end
        if (r.end_of_message) begin
            bit_len = byte_total << 3;
            sha1_absorb(PAD_LEAD);
            while (byte_total[5:0] != LEN_OFFSET) begin
                sha1_absorb(8'h00);
            end
            for (int i = 0; i < 8; i++) begin
                sha1_absorb(bit_len[63 - 8*i -: 8]);
            end
            for (int i = 0; i < NUM_WORDS; i++) begin
                word.digest_word = chain_words[i];
                word.word_number = 3'(i);
                word.last_word   = (i == NUM_WORDS - 1);
                digest_words_due.push_back(word);
            end
            sha1_restart();
        end
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("[%0t] mismatch: %s: got %h, expected %h", $time, what, got, want);
        mismatch_count++;
    endtask

    task automatic queue_request(logic [7:0] b, logic present, logic closing, bit drain);
        t_feed_item item;
        item.req.msg_byte       = b;
        item.req.byte_present   = present;
        item.req.end_of_message = closing;
        item.drain_first        = drain;
        byte_feed.push_back(item);
        stimulus_items++;
    endtask

    // One message with random content; the closing mark rides on the last byte or comes
    // alone, and requests that carry nothing are scattered in between.
    task automatic queue_message(int len, bit drain);
        bit close_on_byte;
        close_on_byte = (len != 0) && ($urandom_range(0, 1) == 1);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 99) < 8) begin
                queue_request(8'($urandom), 1'b0, 1'b0, drain);
                drain = 1'b0;
            end
            queue_request(8'($urandom), 1'b1, close_on_byte && (i == len - 1), drain);
            drain = 1'b0;
        end
        if (!close_on_byte) begin
            queue_request(8'($urandom), 1'b0, 1'b1, drain);
        end
    endtask

    assign sender_calm   = (requests_sent >= 90) && (requests_sent < 160);
    assign receiver_calm = (digests_seen >= 5) && (digests_seen < 9);

    // Request driver.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                sha1_take_request(i_in_data);
                requests_sent++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (byte_feed.size() != 0
                        && (sender_calm || $urandom_range(0, 99) >= IDLE_PERCENT)
                        && !(byte_feed[0].drain_first && digest_words_due.size() != 0)) begin
                    i_in_data  <= byte_feed[0].req;
                    i_in_valid <= 1'b1;
                    byte_feed.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= receiver_calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
        end
    end

    // Digest word monitor.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (digest_words_due.size() == 0) begin
                report_mismatch("digest word with none expected", o_out_data.digest_word, '0);
            end else begin
                due_word = digest_words_due.pop_front();
                if (o_out_data.digest_word !== due_word.digest_word) begin
                    report_mismatch("digest_word", o_out_data.digest_word, due_word.digest_word);
                end
                if (o_out_data.word_number !== due_word.word_number) begin
                    report_mismatch("word_number", 32'(o_out_data.word_number),
                                    32'(due_word.word_number));
                end
                if (o_out_data.last_word !== due_word.last_word) begin
                    report_mismatch("last_word", 32'(o_out_data.last_word),
                                    32'(due_word.last_word));
                end
                if (due_word.last_word) begin
                    digests_seen++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("sha1_byte_stream_hasher verification failed");
            $finish;
        end
    end

    initial begin
        int len;
        int msg_index;
        sha1_restart();

        // Empty message, an ignored request, the "abc" message, extreme byte values,
        // a single byte closing its own message, and an empty message right after one.
        queue_request(8'h00, 1'b0, 1'b1, 1'b0);
        queue_request(8'hA5, 1'b0, 1'b0, 1'b0);
        queue_request(8'h61, 1'b1, 1'b0, 1'b0);
        queue_request(8'h62, 1'b1, 1'b0, 1'b0);
        queue_request(8'h63, 1'b1, 1'b1, 1'b0);
        queue_request(8'h00, 1'b1, 1'b0, 1'b0);
        queue_request(8'hFF, 1'b1, 1'b0, 1'b0);
        queue_request(8'h3C, 1'b0, 1'b1, 1'b0);
        queue_request(8'h80, 1'b1, 1'b1, 1'b0);
        queue_request(8'hFF, 1'b0, 1'b1, 1'b0);

        // Lengths cluster around the point where padding spills into an extra block.
        msg_index = 0;
        while (stimulus_items < ITEM_TARGET) begin
            case ($urandom_range(0, 5))
                0, 1: len = $urandom_range(0, 8);
                2, 3: len = $urandom_range(52, 66);
                4: len = $urandom_range(9, 51);
                default: len = $urandom_range(115, 130);
            endcase
            if (len > ITEM_TARGET - stimulus_items) begin
                len = ITEM_TARGET - stimulus_items;
            end
            queue_message(len, msg_index == 0 || msg_index == 5);
            msg_index++;
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        @(negedge i_clk);
        while (byte_feed.size() != 0 || i_in_valid || digest_words_due.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        if (mismatch_count == 0) begin
            $display("sha1_byte_stream_hasher verification clean");
        end else begin
            $display("sha1_byte_stream_hasher verification failed");
        end
        $finish;
    end

endmodule
